// ----- src/tod_alu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tod_alu_pkg
// Shared types, constants and helpers for the time-of-day arithmetic unit.
// ----------------------------------------------------------------------------
package tod_alu_pkg;

  typedef enum logic [3:0] {
    CMD_VALID    = 4'd0,
    CMD_TO_SEC   = 4'd1,
    CMD_FROM_SEC = 4'd2,
    CMD_EQ       = 4'd3,
    CMD_NE       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GT       = 4'd6,
    CMD_INC      = 4'd7,
    CMD_ADD_N    = 4'd8,
    CMD_DEC      = 4'd9,
    CMD_SUB_N    = 4'd10,
    CMD_DURATION = 4'd11
  } cmd_t;

  localparam logic [16:0] DAY_SECS    = 17'd86400;
  localparam logic [16:0] DAY_SECS_M1 = 17'd86399;
  localparam logic [16:0] HOUR_SECS   = 17'd3600;
  localparam logic [16:0] MIN_SECS    = 17'd60;
  localparam logic [4:0]  HOURS_DAY   = 5'd24;
  localparam logic [5:0]  MIN_MAX     = 6'd59;

  // floor(2^32 / 675); 86400 = 128 * 675
  localparam logic [22:0] DIV675_RECIP = 23'd6362914;
  localparam int          DIV675_SHIFT = 32;
  // ceil(2^27 / 3600), exact for values below 86400
  localparam logic [15:0] HOUR_RECIP   = 16'd37283;
  localparam int          HOUR_SHIFT   = 27;
  // ceil(2^18 / 60), exact for values below 3600
  localparam logic [12:0] MIN_RECIP    = 13'd4370;
  localparam int          MIN_SHIFT    = 18;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  hour_a;
    logic [5:0]  minute_a;
    logic [5:0]  second_a;
    logic [4:0]  hour_b;
    logic [5:0]  minute_b;
    logic [5:0]  second_b;
    logic [31:0] count_n;
  } in_item_t;

  // front end to adder stage
  typedef struct packed {
    cmd_t        cmd;
    logic [16:0] a;
    logic [16:0] nmod;
    logic        flag;
    logic [16:0] dur;
  } front_out_t;

  // adder stage to h/m/s split
  typedef struct packed {
    logic [16:0] secs;
    logic        flag;
    logic        time_en;
  } step_out_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [16:0] secs;
    logic        flag;
  } out_item_t;

  // value known to be below 2*86400
  function automatic logic [16:0] mod_day(input logic [17:0] v);
    logic [17:0] d;
    d = v - {1'b0, DAY_SECS};
    return (v >= {1'b0, DAY_SECS}) ? d[16:0] : v[16:0];
  endfunction

endpackage

// ----- src/time_of_day_alu_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_alu_top
// Stateless time-of-day arithmetic unit with stream request channels.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_*: one request per in_tvalid & in_tready edge. in_tuser
//    carries the command, in_tdata the times A, B and the seconds operand.
//  - Output channel out_*: exactly one result per request, in request order.
//  - Pipeline: 8 register stages (3 front stages for the seconds sums and the
//    count reduction mod 86400, 1 adder stage, 3 stages for the hour/minute
//    split, 1 output register).
//  - Throughput: one request per cycle unless the output stalls; every stage
//    is registered with its own valid bit, so back-to-back requests flow.
//  - Stall: when out_tready is low the full stages hold, empty stages still
//    fill, and in_tready drops once the pipe is full. Nothing is dropped or
//    repeated.
//  - Reset (rst_n low, synchronous): all valid bits clear, in-flight requests
//    are discarded. There is no other state.
// ----------------------------------------------------------------------------
module time_of_day_alu_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // hour_a, minute_a, second_a, hour_b, minute_b,
                                  // second_b, count_n, zero pad
  input  logic [3:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // hour_out, minute_out, second_out, seconds_out,
                                  // flag_out, zero pad
);
  import tod_alu_pkg::*;

  in_item_t   req;
  front_out_t front_data;
  step_out_t  step_data;
  out_item_t  res;
  logic       front_valid, front_ready;
  logic       step_valid, step_ready;

  // unpack the request bus
  assign req.cmd      = cmd_t'(in_tuser);
  assign req.hour_a   = in_tdata[4:0];
  assign req.minute_a = in_tdata[10:5];
  assign req.second_a = in_tdata[16:11];
  assign req.hour_b   = in_tdata[21:17];
  assign req.minute_b = in_tdata[27:22];
  assign req.second_b = in_tdata[33:28];
  assign req.count_n  = in_tdata[65:34];

  // stages 1-3: seconds of A/B, count mod 86400, compares and duration
  tod_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (req),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  // stage 4: time offset add and day wrap
  tod_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (step_valid),
    .out_ready (step_ready),
    .out_data  (step_data)
  );

  // stages 5-8: hour/minute/second split and output register
  tod_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (step_valid),
    .in_ready  (step_ready),
    .in_data   (step_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  // pack the result bus, lowest field first
  assign out_tdata = {5'd0, res.flag, res.secs, res.second, res.minute, res.hour};

endmodule

// ----- src/tod_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tod_front
// Three stages: seconds of A and B, count reduction mod 86400, compares.
// ----------------------------------------------------------------------------
module tod_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tod_alu_pkg::in_item_t   in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tod_alu_pkg::front_out_t out_data
);
  import tod_alu_pkg::*;

  typedef struct packed {
    cmd_t        cmd;
    logic [16:0] raw_a;
    logic [16:0] raw_b;
    logic [15:0] q_est;
    logic [31:0] n;
    logic        time_ok;
    logic        eq;
    logic [16:0] a;
    logic [16:0] b;
    logic [17:0] r;
    logic [16:0] nmod;
    logic        flag;
    logic [16:0] dur;
  } front_stage_t;

  logic         s1_valid_r, s2_valid_r, s3_valid_r;
  front_stage_t s1_r, s2_r, s3_r;
  front_stage_t s1_nxt, s2_nxt, s3_nxt;
  logic         s1_en, s2_en, s3_en;
  logic [47:0]  q_prod;
  logic [31:0]  q_mul;
  logic [31:0]  r_full;
  logic [17:0]  dur_wide;

  assign s3_en    = !s3_valid_r || out_ready;
  assign s2_en    = !s2_valid_r || s3_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  // stage 1: raw seconds sums and quotient estimate of count / 86400
  always_comb begin
    s1_nxt         = '0;
    s1_nxt.cmd     = in_data.cmd;
    s1_nxt.raw_a   = 17'(in_data.hour_a) * HOUR_SECS + 17'(in_data.minute_a) * MIN_SECS
                     + 17'(in_data.second_a);
    s1_nxt.raw_b   = 17'(in_data.hour_b) * HOUR_SECS + 17'(in_data.minute_b) * MIN_SECS
                     + 17'(in_data.second_b);
    q_prod         = 48'(in_data.count_n[31:7]) * 48'(DIV675_RECIP);
    s1_nxt.q_est   = q_prod[47:DIV675_SHIFT];
    s1_nxt.n       = in_data.count_n;
    s1_nxt.time_ok = (in_data.hour_a < HOURS_DAY) && (in_data.minute_a <= MIN_MAX)
                     && (in_data.second_a <= MIN_MAX);
    s1_nxt.eq      = (in_data.hour_a == in_data.hour_b)
                     && (in_data.minute_a == in_data.minute_b)
                     && (in_data.second_a == in_data.second_b);
  end

  // stage 2: wrap A and B into one day, partial remainder (below 2*86400)
  always_comb begin
    s2_nxt   = s1_r;
    s2_nxt.a = mod_day({1'b0, s1_r.raw_a});
    s2_nxt.b = mod_day({1'b0, s1_r.raw_b});
    q_mul    = 32'(s1_r.q_est) * 32'(DAY_SECS);
    r_full   = s1_r.n - q_mul;
    s2_nxt.r = r_full[17:0];
  end

  // stage 3: final remainder, compare flag, duration
  always_comb begin
    s3_nxt      = s2_r;
    s3_nxt.nmod = mod_day(s2_r.r);
    dur_wide    = {1'b0, DAY_SECS} + {1'b0, s2_r.b} - {1'b0, s2_r.a};
    s3_nxt.dur  = (s2_r.b > s2_r.a) ? (s2_r.b - s2_r.a) : dur_wide[16:0];
    unique case (s2_r.cmd)
      CMD_VALID: s3_nxt.flag = s2_r.time_ok;
      CMD_EQ:    s3_nxt.flag = s2_r.eq;
      CMD_NE:    s3_nxt.flag = !s2_r.eq;
      CMD_LT:    s3_nxt.flag = (s2_r.a < s2_r.b);
      CMD_GT:    s3_nxt.flag = (s2_r.a > s2_r.b);
      default:   s3_nxt.flag = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
      if (s3_en) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) s1_r <= s1_nxt;
    if (s2_en) s2_r <= s2_nxt;
    if (s3_en) s3_r <= s3_nxt;
  end

  assign out_valid     = s3_valid_r;
  assign out_data.cmd  = s3_r.cmd;
  assign out_data.a    = s3_r.a;
  assign out_data.nmod = s3_r.nmod;
  assign out_data.flag = s3_r.flag;
  assign out_data.dur  = s3_r.dur;

`ifndef ASSERT_OFF
  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_r.nmod < DAY_SECS) && (s3_r.a < DAY_SECS) && (s3_r.dur <= DAY_SECS))
    else $error("front: reduced value out of day range");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !out_ready |=> s3_valid_r && $stable(s3_r))
    else $error("front: stalled stage changed");
`endif

endmodule

// ----- src/tod_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tod_step
// One stage: offset add, wrap into one day, pick the seconds result.
// ----------------------------------------------------------------------------
module tod_step (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tod_alu_pkg::front_out_t in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tod_alu_pkg::step_out_t  out_data
);
  import tod_alu_pkg::*;

  logic        valid_r;
  step_out_t   data_r, data_nxt;
  logic        en;
  logic [17:0] sum;
  logic [16:0] t_day;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    case (in_data.cmd)
      CMD_FROM_SEC: sum = {1'b0, in_data.nmod};
      CMD_INC:      sum = {1'b0, in_data.a} + 18'd1;
      CMD_ADD_N:    sum = {1'b0, in_data.a} + {1'b0, in_data.nmod};
      CMD_DEC:      sum = {1'b0, in_data.a} + {1'b0, DAY_SECS_M1};
      CMD_SUB_N:    sum = {1'b0, in_data.a} + {1'b0, DAY_SECS} - {1'b0, in_data.nmod};
      default:      sum = '0;
    endcase
    t_day = mod_day(sum);

    data_nxt      = '0;
    data_nxt.flag = in_data.flag;
    unique case (in_data.cmd) inside
      CMD_TO_SEC:   data_nxt.secs = in_data.a;
      CMD_DURATION: data_nxt.secs = in_data.dur;
      CMD_FROM_SEC, CMD_INC, CMD_ADD_N, CMD_DEC, CMD_SUB_N: begin
        data_nxt.secs    = t_day;
        data_nxt.time_en = 1'b1;
      end
      default:      data_nxt.secs = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- src/tod_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tod_split
// Four stages: seconds of day into hour, minute and second; output register.
// ----------------------------------------------------------------------------
module tod_split (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tod_alu_pkg::step_out_t in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tod_alu_pkg::out_item_t out_data
);
  import tod_alu_pkg::*;

  typedef struct packed {
    logic [16:0] secs;
    logic        flag;
    logic        time_en;
    logic [4:0]  hour;
    logic [11:0] rem;
    logic [5:0]  minute;
  } split_stage_t;

  logic         s5_valid_r, s6_valid_r, s7_valid_r, s8_valid_r;
  split_stage_t s5_r, s6_r, s7_r;
  split_stage_t s5_nxt, s6_nxt, s7_nxt;
  out_item_t    s8_r, s8_nxt;
  logic         s5_en, s6_en, s7_en, s8_en;
  logic [31:0]  h_prod;
  logic [16:0]  rem_full;
  logic [24:0]  m_prod;
  logic [11:0]  s_full;

  assign s8_en    = !s8_valid_r || out_ready;
  assign s7_en    = !s7_valid_r || s8_en;
  assign s6_en    = !s6_valid_r || s7_en;
  assign s5_en    = !s5_valid_r || s6_en;
  assign in_ready = s5_en;

  always_comb begin
    s5_nxt         = '0;
    s5_nxt.secs    = in_data.secs;
    s5_nxt.flag    = in_data.flag;
    s5_nxt.time_en = in_data.time_en;
    h_prod         = 32'(in_data.secs) * 32'(HOUR_RECIP);
    s5_nxt.hour    = 5'(h_prod >> HOUR_SHIFT);
  end

  always_comb begin
    s6_nxt     = s5_r;
    rem_full   = s5_r.secs - 17'(s5_r.hour) * HOUR_SECS;
    s6_nxt.rem = rem_full[11:0];
  end

  always_comb begin
    s7_nxt        = s6_r;
    m_prod        = 25'(s6_r.rem) * 25'(MIN_RECIP);
    s7_nxt.minute = 6'(m_prod >> MIN_SHIFT);
  end

  // time fields only for commands that produce a time
  always_comb begin
    s_full      = s7_r.rem - 12'(s7_r.minute) * 12'(MIN_SECS);
    s8_nxt.secs = s7_r.secs;
    s8_nxt.flag = s7_r.flag;
    if (s7_r.time_en) begin
      s8_nxt.hour   = s7_r.hour;
      s8_nxt.minute = s7_r.minute;
      s8_nxt.second = s_full[5:0];
    end else begin
      s8_nxt.hour   = '0;
      s8_nxt.minute = '0;
      s8_nxt.second = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
    end else begin
      if (s5_en) s5_valid_r <= in_valid;
      if (s6_en) s6_valid_r <= s5_valid_r;
      if (s7_en) s7_valid_r <= s6_valid_r;
      if (s8_en) s8_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_en) s5_r <= s5_nxt;
    if (s6_en) s6_r <= s6_nxt;
    if (s7_en) s7_r <= s7_nxt;
    if (s8_en) s8_r <= s8_nxt;
  end

  assign out_valid = s8_valid_r;
  assign out_data  = s8_r;

`ifndef ASSERT_OFF
  a_split_recombine: assert property (@(posedge clk) disable iff (!rst_n)
    s8_valid_r && (s8_r.hour != 5'd0 || s8_r.minute != 6'd0 || s8_r.second != 6'd0)
    |-> (17'(s8_r.hour) * HOUR_SECS + 17'(s8_r.minute) * MIN_SECS
         + 17'(s8_r.second)) == s8_r.secs)
    else $error("split: h/m/s do not match seconds");

  a_split_flag_only: assert property (@(posedge clk) disable iff (!rst_n)
    s8_valid_r && s8_r.flag |-> (s8_r.secs == 17'd0) && (s8_r.hour == 5'd0))
    else $error("split: flag result carries time data");
`endif

endmodule
